// ----- rtl/pidc_pkg.sv -----
// pidc_pkg: shared widths, register indexes and state types of the pid step
// block. Used by pid_controller_step; the arithmetic units take plain
// parameters.
package pidc_pkg;

  // field widths
  localparam int DATA_W   = 32;
  localparam int LIMIT_W  = 31;
  localparam int PERIOD_W = 16;
  localparam int INTEG_W  = 48;
  localparam int DERIV_W  = 43;

  // serial multiplier: 80-bit multiplicand, 32-bit multiplier
  localparam int MAG_W   = 48;
  localparam int MCAND_W = 80;
  localparam int MPLR_W  = 32;
  localparam int PROD_W  = MCAND_W + MPLR_W;

  // serial divider numerator
  localparam int NUM_W = 48;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_K   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd6;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd1;

  // milliseconds per second, as multiplier and as divisor
  localparam logic [MPLR_W-1:0]   MS_PER_S     = 32'd1000;
  localparam logic [PERIOD_W-1:0] MS_DIVISOR   = 16'd1000;
  localparam logic [MCAND_W-1:0]  MS_HALF_BIAS = 80'd500;

  // term saturation bounds
  localparam logic [DATA_W-1:0] TERM_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] TERM_NEG_MAG = 32'h8000_0000;

  // integral saturation bounds
  localparam logic [INTEG_W-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [INTEG_W-1:0] INTEG_MIN = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DMUL,
    S_DDIV,
    S_IMUL,
    S_IDIV,
    S_IUPD,
    S_TMUL1,
    S_TMUL2,
    S_TSAT,
    S_SUM
  } state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

endpackage

// ----- rtl/pidc_mul.sv -----
// pidc_mul: radix-4 serial-parallel multiplier, multiplier consumed two bits
// per cycle from a shift register, product low bits shifted into the same
// register. No package dependency.
module pidc_mul #(
  parameter int MW = 80,
  parameter int QW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             half,
  input  logic [MW-1:0]    mcand,
  input  logic [MW-1:0]    bias,
  input  logic [QW-1:0]    mplr,
  output logic             busy,
  output logic             done,
  output logic [MW+QW-1:0] prod
);

  localparam int CW = $clog2(QW / 2);

  logic [MW-1:0] mc_r;
  logic [MW+1:0] mc3_r;
  logic [MW-1:0] hi_r, hi_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [MW+1:0] addend, sum;

  // digit times multiplicand, 3x kept from start
  always_comb begin
    case (lo_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, mc_r};
      2'd2:    addend = {1'b0, mc_r, 1'b0};
      2'd3:    addend = mc3_r;
      default: addend = '0;
    endcase
  end

  assign sum    = {2'b00, hi_r} + addend;
  assign hi_nxt = sum[MW+1:2];
  assign lo_nxt = {sum[1:0], lo_r[QW-1:2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= half ? CW'(QW / 4 - 1) : CW'(QW / 2 - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      mc3_r <= {2'b00, mcand} + {1'b0, mcand, 1'b0};
      hi_r  <= bias;
      lo_r  <= mplr;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == '0);
  assign prod = {hi_r, lo_r};

endmodule

// ----- rtl/pidc_div.sv -----
// pidc_div: restoring divider, one quotient bit per cycle, numerator shifted
// out msb first while quotient bits shift in. No package dependency.
module pidc_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] qn_r, qn_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial, diff;
  logic          fits;

  assign trial   = {rem_r, qn_r[NW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign fits    = !diff[DW];
  assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
  assign qn_nxt  = {qn_r[NW-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      qn_r  <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qn_r  <= qn_nxt;
    end
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == '0);
  assign quo  = qn_r;

endmodule

// ----- rtl/pid_controller_step.sv -----
// pid_controller_step: one pid step per measured sample with output clamp.
// Depends on pidc_pkg, pidc_mul (serial multiplier) and pidc_div (serial
// divider).
//
// usage
// - input channel in_valid / in_stall / in_measured: one signed q16.16 sample
//   per item, taken when in_valid is high and in_stall is low
// - result channel out_valid / out_stall: drive, the three terms and the
//   clamp flag, taken when out_valid is high and out_stall is low
// - config channel cfg_valid / cfg_ready / cfg_index / cfg_data: gains, limit,
//   setpoint and period; writing the setpoint clears the integral
// - steps per item, in order: derivative multiply and divide, integral multiply
//   and divide, integral update, two multiplier passes and a saturation per term, sum
// - that is two divisions, six full and two half radix-4 multiplier passes;
//   no new item is taken until the result is loaded into the output register
// - the result sits in an output register; while the receiver stalls it holds
//   there and a new item is still taken and worked on, and a second result
//   waits inside until the register frees up
// - reset clears state, out_valid, config, integral and previous sample; period is 10
// - cfg writes are taken only while no item is in progress
module pid_controller_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pidc_pkg::DATA_W-1:0]   in_measured,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidc_pkg::DATA_W-1:0]   out_drive,
  output logic signed [pidc_pkg::DATA_W-1:0]   out_prop_term,
  output logic signed [pidc_pkg::DATA_W-1:0]   out_integ_term,
  output logic signed [pidc_pkg::DATA_W-1:0]   out_deriv_term,
  output logic                                 out_clamped,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]          cfg_data
);

  import pidc_pkg::*;

  // triple product is shifted right by twice the fraction width
  localparam int TermShift = 2 * FRAC_BITS;
  localparam logic [MCAND_W-1:0] TermBias = MCAND_W'(1) << (TermShift - 1);

  // control state
  state_t state_r, state_nxt;
  term_t  tsel_r;
  logic   out_valid_r;

  // configuration
  logic signed [DATA_W-1:0] gain_k_r, gain_p_r, gain_i_r, gain_d_r, setpt_r;
  logic [LIMIT_W-1:0]       limit_r;
  logic [PERIOD_W-1:0]      period_r;

  // loop state
  logic signed [DATA_W-1:0]  prev_r;
  logic signed [INTEG_W-1:0] integ_r;

  // per item working registers
  logic signed [DATA_W-1:0] meas_r;
  logic [DERIV_W-1:0]       dmag_r;
  logic signed [DATA_W-1:0] pt_r, it_r, dt_r;

  // output register
  logic signed [DATA_W-1:0] drive_r, prop_r, integ_out_r, deriv_out_r;
  logic                     clamped_r;

  // handshakes
  logic in_fire, cfg_fire, load_out;

  // unit hookup
  logic                mul_start, mul_half, mul_busy, mul_done;
  logic [MCAND_W-1:0]  mul_mcand, mul_bias;
  logic [MPLR_W-1:0]   mul_mplr;
  logic [PROD_W-1:0]   mul_prod;
  logic [NUM_W-1:0]    short_prod;
  logic                div_start, div_busy, div_done;
  logic [NUM_W-1:0]    div_num, div_quo;
  logic [PERIOD_W-1:0] div_den;

  // arithmetic helpers
  logic [PERIOD_W-1:0]      per_eff;
  logic [DATA_W:0]          err_w, err_abs, delta_w, delta_abs;
  logic                     err_neg, delta_neg;
  logic [DATA_W-1:0]        err_mag, delta_mag, k_mag, coef_mag;
  logic [INTEG_W-1:0]       integ_abs;
  logic signed [DATA_W-1:0] coef;
  logic [MAG_W-1:0]         x_mag;
  logic                     x_neg, t_neg;
  logic                     rnd_hi_nz;
  logic [DATA_W-1:0]        rnd_low, t_lim, t_mag, t_val;
  logic signed [INTEG_W:0]  integ_sum;
  logic [INTEG_W-1:0]       integ_upd;
  logic signed [DATA_W+1:0] sum_all, lim_ext;
  logic [DATA_W-1:0]        drive_val;
  logic                     clip_val;

  assign in_fire  = in_valid && !in_stall;
  assign cfg_fire = cfg_valid && cfg_ready;

  // a period of zero counts as one millisecond
  assign per_eff = (period_r == '0) ? PERIOD_MIN : period_r;

  // error against setpoint and change of the measurement, 33 bits each
  assign err_w     = {setpt_r[DATA_W-1], setpt_r} - {meas_r[DATA_W-1], meas_r};
  assign err_neg   = err_w[DATA_W];
  assign err_abs   = err_neg ? (~err_w + 1'b1) : err_w;
  assign err_mag   = err_abs[DATA_W-1:0];
  assign delta_w   = {meas_r[DATA_W-1], meas_r} - {prev_r[DATA_W-1], prev_r};
  assign delta_neg = delta_w[DATA_W];
  assign delta_abs = delta_neg ? (~delta_w + 1'b1) : delta_w;
  assign delta_mag = delta_abs[DATA_W-1:0];

  assign integ_abs = integ_r[INTEG_W-1] ? (~integ_r + 1'b1) : integ_r;
  assign k_mag     = gain_k_r[DATA_W-1] ? (~gain_k_r + 1'b1) : gain_k_r;

  // operand and sign of the term being worked on
  always_comb begin
    case (tsel_r)
      TERM_P: begin
        coef  = gain_p_r;
        x_mag = MAG_W'(err_mag);
        x_neg = err_neg;
      end
      TERM_I: begin
        coef  = gain_i_r;
        x_mag = integ_abs;
        x_neg = integ_r[INTEG_W-1];
      end
      TERM_D: begin
        coef  = gain_d_r;
        x_mag = MAG_W'(dmag_r);
        x_neg = delta_neg;
      end
      default: begin
        coef  = '0;
        x_mag = '0;
        x_neg = 1'b0;
      end
    endcase
  end

  assign coef_mag = coef[DATA_W-1] ? (~coef + 1'b1) : coef;
  assign t_neg    = gain_k_r[DATA_W-1] ^ coef[DATA_W-1] ^ x_neg;

  // rounding bias already went in through the multiplier, so just shift,
  // saturate to the 32-bit range and restore the sign
  assign rnd_hi_nz = |mul_prod[PROD_W-1:TermShift+DATA_W];
  assign rnd_low   = mul_prod[TermShift+DATA_W-1:TermShift];
  assign t_lim     = t_neg ? TERM_NEG_MAG : TERM_POS_MAX;
  assign t_mag     = (rnd_hi_nz || (rnd_low > t_lim)) ? t_lim : rnd_low;
  assign t_val     = t_neg ? (~t_mag + 1'b1) : t_mag;

  // half multiplier passes take only the low 16 multiplier bits, so their product sits 16 bits up
  assign short_prod = mul_prod[MPLR_W/2 +: NUM_W];

  // integral plus rounded increment, saturated to 48 bits
  assign integ_sum = err_neg ? ({integ_r[INTEG_W-1], integ_r} - (INTEG_W+1)'(div_quo))
                             : ({integ_r[INTEG_W-1], integ_r} + (INTEG_W+1)'(div_quo));
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_upd = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_upd = integ_sum[INTEG_W-1:0];
    end
  end

  // sum of terms and symmetric clamp
  assign sum_all = {{2{pt_r[DATA_W-1]}}, pt_r} + {{2{it_r[DATA_W-1]}}, it_r}
                 + {{2{dt_r[DATA_W-1]}}, dt_r};
  assign lim_ext = {3'b000, limit_r};
  always_comb begin
    if (sum_all > lim_ext) begin
      drive_val = lim_ext[DATA_W-1:0];
      clip_val  = 1'b1;
    end else if (sum_all < -lim_ext) begin
      drive_val = (~lim_ext[DATA_W-1:0]) + 1'b1;
      clip_val  = 1'b1;
    end else begin
      drive_val = sum_all[DATA_W-1:0];
      clip_val  = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_DMUL;
      S_DMUL:  if (mul_done) state_nxt = S_DDIV;
      S_DDIV:  if (div_done) state_nxt = S_IMUL;
      S_IMUL:  if (mul_done) state_nxt = S_IDIV;
      S_IDIV:  if (div_done) state_nxt = S_IUPD;
      S_IUPD:  state_nxt = S_TMUL1;
      S_TMUL1: if (mul_done) state_nxt = S_TMUL2;
      S_TMUL2: if (mul_done) state_nxt = S_TSAT;
      S_TSAT:  state_nxt = (tsel_r == TERM_D) ? S_SUM : S_TMUL1;
      S_SUM:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: unit launches and operand selection;
  // a unit is launched in the first cycle of its state, when it is not busy
  always_comb begin
    mul_start = 1'b0;
    mul_half  = 1'b0;
    mul_mcand = '0;
    mul_mplr  = '0;
    mul_bias  = '0;
    div_start = 1'b0;
    div_num   = short_prod;
    div_den   = per_eff;
    case (state_r)
      S_DMUL: begin
        // |delta| * 1000 + period/2
        mul_start = !mul_busy;
        mul_half  = 1'b1;
        mul_mcand = MCAND_W'(delta_mag);
        mul_mplr  = MS_PER_S;
        mul_bias  = MCAND_W'(per_eff >> 1);
      end
      S_DDIV: begin
        div_start = !div_busy;
        div_den   = per_eff;
      end
      S_IMUL: begin
        // |error| * period + 500
        mul_start = !mul_busy;
        mul_half  = 1'b1;
        mul_mcand = MCAND_W'(err_mag);
        mul_mplr  = MPLR_W'(per_eff);
        mul_bias  = MS_HALF_BIAS;
      end
      S_IDIV: begin
        div_start = !div_busy;
        div_den   = MS_DIVISOR;
      end
      S_TMUL1: begin
        // |x| * |coef|
        mul_start = !mul_busy;
        mul_mcand = MCAND_W'(x_mag);
        mul_mplr  = coef_mag;
      end
      S_TMUL2: begin
        // previous product * |K| plus half an lsb of the result
        mul_start = !mul_busy;
        mul_mcand = mul_prod[MCAND_W-1:0];
        mul_mplr  = k_mag;
        mul_bias  = TermBias;
      end
      default: begin
      end
    endcase
  end

  assign load_out  = (state_r == S_SUM) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // control and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tsel_r      <= TERM_P;
      out_valid_r <= 1'b0;
      gain_k_r    <= '0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      limit_r     <= '0;
      setpt_r     <= '0;
      period_r    <= PERIOD_RESET;
      prev_r      <= '0;
      integ_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_IUPD) begin
        tsel_r <= TERM_P;
      end else if (state_r == S_TSAT) begin
        tsel_r <= (tsel_r == TERM_P) ? TERM_I : TERM_D;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_IUPD) begin
        integ_r <= integ_upd;
      end

      if (load_out) begin
        prev_r <= meas_r;
      end

      if (cfg_fire) begin
        case (cfg_index)
          CFG_GAIN_K: gain_k_r <= cfg_data;
          CFG_GAIN_P: gain_p_r <= cfg_data;
          CFG_GAIN_I: gain_i_r <= cfg_data;
          CFG_GAIN_D: gain_d_r <= cfg_data;
          CFG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
          CFG_SETPOINT: begin
            setpt_r <= cfg_data;
            integ_r <= '0;
          end
          CFG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      meas_r <= in_measured;
    end
    // derivative quotient is still in the divider until the integral division
    if (state_r == S_IMUL) begin
      dmag_r <= div_quo[DERIV_W-1:0];
    end
    if (state_r == S_TSAT) begin
      case (tsel_r)
        TERM_P:  pt_r <= t_val;
        TERM_I:  it_r <= t_val;
        TERM_D:  dt_r <= t_val;
        default: pt_r <= t_val;
      endcase
    end
    if (load_out) begin
      drive_r     <= drive_val;
      prop_r      <= pt_r;
      integ_out_r <= it_r;
      deriv_out_r <= dt_r;
      clamped_r   <= clip_val;
    end
  end

  pidc_mul #(
    .MW(MCAND_W),
    .QW(MPLR_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .half  (mul_half),
    .mcand (mul_mcand),
    .bias  (mul_bias),
    .mplr  (mul_mplr),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pidc_div #(
    .NW(NUM_W),
    .DW(PERIOD_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid      = out_valid_r;
  assign out_drive      = drive_r;
  assign out_prop_term  = prop_r;
  assign out_integ_term = integ_out_r;
  assign out_deriv_term = deriv_out_r;
  assign out_clamped    = clamped_r;

endmodule

// ----- sim/pid_controller_step_tb.sv -----
// pid_controller_step_tb: self-checking bench for the pid step block with output clamp.
// Holds a bit-true fixed-point predictor, a paced sample driver, a stalling result
// monitor and a config writer. Depends on pidc_pkg and pid_controller_step.
`timescale 1ns / 100ps

module pid_controller_step_tb;

  localparam int FRAC_BITS = 16;

  // no handshake of any kind for this long means the block is stuck
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // length of the quiet tail at the end of the run
  localparam int unsigned DRAIN_CYCLES   = 250;
  // one long receiver hold-off, long enough to fill the block and stall input
  localparam int unsigned SQUEEZE_AT     = 300;
  localparam int unsigned SQUEEZE_CYCLES = 3000;

  // config index the block does not map; writes to it must be dropped
  localparam logic [pidc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam longint INTEG_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_BOT = -INTEG_TOP - 1;
  localparam longint MS_PER_S  = 1000;

  typedef struct {
    int drive;
    int prop_term;
    int integ_term;
    int deriv_term;
    bit clamped;
  } pid_outputs_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                                in_valid    = 1'b0;
  logic                                in_stall;
  logic signed [pidc_pkg::DATA_W-1:0]  in_measured = '0;

  logic                                out_valid;
  logic                                out_stall   = 1'b0;
  logic signed [pidc_pkg::DATA_W-1:0]  out_drive;
  logic signed [pidc_pkg::DATA_W-1:0]  out_prop_term;
  logic signed [pidc_pkg::DATA_W-1:0]  out_integ_term;
  logic signed [pidc_pkg::DATA_W-1:0]  out_deriv_term;
  logic                                out_clamped;

  logic                                cfg_valid   = 1'b0;
  logic                                cfg_ready;
  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [pidc_pkg::DATA_W-1:0]         cfg_data    = '0;

  pid_controller_step #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_measured   (in_measured),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive     (out_drive),
    .out_prop_term (out_prop_term),
    .out_integ_term(out_integ_term),
    .out_deriv_term(out_deriv_term),
    .out_clamped   (out_clamped),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: shadow copy of the registers and the loop state
  // ---------------------------------------------------------------------------
  logic signed [31:0] k_gain       = '0;
  logic signed [31:0] p_gain       = '0;
  logic signed [31:0] i_gain       = '0;
  logic signed [31:0] d_gain       = '0;
  logic        [30:0] limit_cfg    = '0;
  logic signed [31:0] setpoint_cfg = '0;
  logic        [15:0] period_cfg   = pidc_pkg::PERIOD_RESET;
  longint             prev_meas    = 0;
  longint             integ_acc    = 0;

  pid_outputs_t       predicted_outputs[$];
  logic [31:0]        samples_to_send[$];
  int unsigned        fail_count = 0;

  // integer quotient rounded to nearest, ties away from zero; den is positive
  function automatic longint div_nearest(input longint num, input longint den);
    longint q;
    q = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // round(coef * x / 2^(2*frac)) on the exact wide product, then clip to 32 bits
  function automatic int gain_term(input longint coef, input longint x);
    logic [127:0] prod;
    logic         neg;
    neg  = (coef < 0) != (x < 0);
    prod = {64'd0, magnitude(coef)} * {64'd0, magnitude(x)};
    prod = (prod + (128'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    if (neg) begin
      if (prod > 128'h8000_0000) prod = 128'h8000_0000;
      return -int'(prod[31:0]);
    end
    if (prod > 128'h7FFF_FFFF) prod = 128'h7FFF_FFFF;
    return int'(prod[31:0]);
  endfunction

  function automatic void apply_cfg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      pidc_pkg::CFG_GAIN_K: k_gain = data;
      pidc_pkg::CFG_GAIN_P: p_gain = data;
      pidc_pkg::CFG_GAIN_I: i_gain = data;
      pidc_pkg::CFG_GAIN_D: d_gain = data;
      pidc_pkg::CFG_LIMIT:  limit_cfg = data[30:0];
      pidc_pkg::CFG_SETPOINT: begin
        setpoint_cfg = data;
        integ_acc    = 0;   // new setpoint restarts the integral
      end
      pidc_pkg::CFG_PERIOD: period_cfg = data[15:0];
      default: ;
    endcase
  endfunction

  // one control step for an accepted sample; queues the result it must produce
  function automatic void compute_pid_step(input logic signed [31:0] meas);
    longint       per;
    longint       err;
    longint       slope;
    longint       integ;
    longint       total;
    longint       lim;
    pid_outputs_t r;
    per   = (period_cfg == '0) ? 1 : longint'(period_cfg);  // zero period acts as one
    err   = longint'(setpoint_cfg) - longint'(meas);
    // derivative on the measurement, against the sample before this one
    slope = div_nearest((longint'(meas) - prev_meas) * MS_PER_S, per);
    integ = integ_acc + div_nearest(err * per, MS_PER_S);
    if (integ > INTEG_TOP) integ = INTEG_TOP;
    else if (integ < INTEG_BOT) integ = INTEG_BOT;
    integ_acc = integ;

    r.prop_term  = gain_term(longint'(k_gain) * longint'(p_gain), err);
    r.integ_term = gain_term(longint'(k_gain) * longint'(i_gain), integ);
    r.deriv_term = gain_term(longint'(k_gain) * longint'(d_gain), slope);
    total = longint'(r.prop_term) + longint'(r.integ_term) + longint'(r.deriv_term);
    lim   = longint'(limit_cfg);
    r.clamped = 1'b1;
    if (total > lim) r.drive = int'(lim);
    else if (total < -lim) r.drive = int'(-lim);
    else begin
      r.drive   = int'(total);
      r.clamped = 1'b0;
    end
    prev_meas = meas;
    predicted_outputs.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // random shapes
  // ---------------------------------------------------------------------------
  // idle length: zero with the given percentage, else mostly short, a few long
  function automatic int unsigned idle_len(input int unsigned zero_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < zero_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 5);
    if (r < 95) return $urandom_range(6, 60);
    return $urandom_range(150, 450);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      4, 5: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;   // within +-4.0
    endcase
  endfunction

  // top bit is dropped by the 31-bit register, so full words are fine here
  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h3F_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] small_step();
    return $urandom_range(0, 32'h1_FFFF) - 32'h1_0000;
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: offers queued samples with random gaps between items
  // ---------------------------------------------------------------------------
  int unsigned send_gap   = 0;
  int unsigned sent_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      send_gap   <= 0;
      sent_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        compute_pid_step(in_measured);
        sent_count <= sent_count + 1;
      end
      // a stalled item stays on the port unchanged
      if (!(in_valid && in_stall)) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (samples_to_send.size() != 0) begin
          in_valid    <= 1'b1;
          in_measured <= samples_to_send.pop_front();
          // every fifth window of items goes back to back
          send_gap    <= ((sent_count / 48) % 5 == 2) ? 0 : idle_len(45);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver pacing: random stalls, quiet windows and one long hold-off
  // ---------------------------------------------------------------------------
  int unsigned stall_left   = 0;
  int unsigned taken_count  = 0;
  logic        squeeze_done = 1'b0;

  always @(posedge clk) begin : rx_pace
    int unsigned hold;
    if (!rst_n) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      taken_count  <= 0;
      squeeze_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) taken_count <= taken_count + 1;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;   // out_stall stays high
      end else if (!squeeze_done && taken_count == SQUEEZE_AT) begin
        // sender keeps going, so the block fills and pushes back on input
        squeeze_done <= 1'b1;
        out_stall    <= 1'b1;
        stall_left   <= SQUEEZE_CYCLES - 1;
      end else begin
        hold       = ((taken_count / 40) % 5 == 3) ? 0 : idle_len(96);
        out_stall  <= (hold != 0);
        stall_left <= (hold != 0) ? hold - 1 : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compare each taken item with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    pid_outputs_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        fail_count++;
        $error("result item with no prediction waiting");
      end else begin
        want = predicted_outputs.pop_front();
        check_field("drive", want.drive, out_drive);
        check_field("prop_term", want.prop_term, out_prop_term);
        check_field("integ_term", want.integ_term, out_integ_term);
        check_field("deriv_term", want.deriv_term, out_deriv_term);
        check_field("clamped", want.clamped, out_clamped);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no channel moves for too long
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // config writes and the idle check between phases
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_cfg(idx, data);
  endtask

  // gains and limit only; the integral carries over
  task automatic load_gains(input logic [31:0] k, input logic [31:0] p,
                            input logic [31:0] i, input logic [31:0] d,
                            input logic [31:0] lim);
    write_reg(pidc_pkg::CFG_GAIN_K, k);
    write_reg(pidc_pkg::CFG_GAIN_P, p);
    write_reg(pidc_pkg::CFG_GAIN_I, i);
    write_reg(pidc_pkg::CFG_GAIN_D, d);
    write_reg(pidc_pkg::CFG_LIMIT, lim);
    @(negedge clk);
  endtask

  task automatic load_config(input logic [31:0] k, input logic [31:0] p,
                             input logic [31:0] i, input logic [31:0] d,
                             input logic [31:0] lim, input logic [31:0] sp,
                             input logic [31:0] per);
    load_gains(k, p, i, d, lim);
    write_reg(pidc_pkg::CFG_SETPOINT, sp);
    write_reg(pidc_pkg::CFG_PERIOD, per);
    @(negedge clk);
  endtask

  // idle: nothing queued, nothing on the port, every result back
  task automatic wait_idle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || predicted_outputs.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] sp;
    logic [31:0] level;
    logic [31:0] per;
    int unsigned pick;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero gains give zero terms; first derivative against zero
    samples_to_send.push_back(32'h7FFF_FFFF);
    samples_to_send.push_back(32'h8000_0000);
    wait_idle();

    // unit K and P gains, I 0.5, D 0.25, wide limit; full-scale swings saturate the derivative term
    load_config(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_000A);
    samples_to_send.push_back(32'h0000_0000);
    samples_to_send.push_back(32'h0000_0001);
    samples_to_send.push_back(32'hFFFF_FFFF);
    samples_to_send.push_back(32'h7FFF_FFFF);
    samples_to_send.push_back(32'h8000_0000);
    samples_to_send.push_back(32'h0001_0000);
    wait_idle();

    // extreme gains, zero limit pins drive at zero, zero period acts as one,
    // plus a write to an unmapped index that must change nothing
    load_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    @(negedge clk);
    samples_to_send.push_back(32'h8000_0000);
    samples_to_send.push_back(32'h7FFF_FFFF);
    samples_to_send.push_back(32'h0000_0000);
    samples_to_send.push_back(32'h1234_5678);
    wait_idle();

    // longest period, limit of 5.0 written with the spare top bit set,
    // period written with junk above bit 15; clamps on both sides
    load_config(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'hFFFF_0000,
                32'h8005_0000, 32'h0001_0000, 32'hABCD_FFFF);
    samples_to_send.push_back(32'h0001_0000);
    samples_to_send.push_back(32'h0001_8000);
    samples_to_send.push_back(32'h0000_8000);
    samples_to_send.push_back(32'hFFFF_0000);
    samples_to_send.push_back(32'h0003_0000);
    samples_to_send.push_back(32'hFFFC_0000);
    wait_idle();

    // half-lsb products and period 500: exact ties round away from zero
    load_config(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h7FFF_FFFF, 32'h0000_0000, 32'd500);
    samples_to_send.push_back(32'hFFFF_FFFF);
    samples_to_send.push_back(32'h0000_0001);
    samples_to_send.push_back(32'h0000_0003);
    samples_to_send.push_back(32'hFFFF_FFFD);
    wait_idle();

    // random settings; samples mostly drift or sit near the setpoint
    for (int ph = 0; ph < 5; ph++) begin
      sp = (ph == 0) ? 32'h8000_0000 : rand_word();
      case ($urandom_range(0, 5))
        0: per = 32'h0000_0000;
        1: per = 32'h0000_0001;
        2: per = 32'h0000_FFFF;
        3: per = $urandom;
        default: per = $urandom_range(1, 100);
      endcase
      load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_limit(), sp, per);
      level = sp;
      repeat (8) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) level = level + small_step();
        else if (pick < 7) level = sp + small_step();
        else level = rand_word();
        samples_to_send.push_back(level);
      end
      wait_idle();
    end

    // windup: maximum setpoint, longest period, samples near the bottom of the
    // range; about 500 steps drive the integral into its upper bound. gains
    // and limit change between batches, the setpoint is left alone
    load_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                32'h7FFF_FFFF, 32'h0000_FFFF);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0)
        load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_limit());
      repeat (64) samples_to_send.push_back(32'h8000_0000 + $urandom_range(0, 32'hF_FFFF));
      wait_idle();
    end

    // quiet tail: anything arriving now has no prediction
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
